@@ hw/rtl/mat_pkg.sv @@
// ----------------------------------------------------------------------------
// mat_pkg
// shared constants, codes and types of the moving average trend check
// ----------------------------------------------------------------------------
package mat_pkg;

   localparam int MAX_WINDOW   = 64;
   localparam int SAMPLE_WIDTH = 32;

   localparam int THRESH_W  = 32;
   localparam int STEP_LIM_W = 31;
   localparam int WLEN_W    = 7;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam int PTR_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
   localparam int EFF_W   = (WIN_W > WLEN_W) ? WIN_W : WLEN_W;
   localparam int SUM_W   = SAMPLE_WIDTH + $clog2(MAX_WINDOW);
   localparam int DIV_CNT_W = $clog2(SUM_W + 1);
   localparam int CMP_W   = ((SAMPLE_WIDTH > THRESH_W) ? SAMPLE_WIDTH : THRESH_W) + 1;
   localparam int DIFF_W  = SAMPLE_WIDTH + 1;
   localparam int STEP_W  = (DIFF_W > STEP_LIM_W) ? DIFF_W : STEP_LIM_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD_LOW  = 2'd0,
      CSR_THRESHOLD_HIGH = 2'd1,
      CSR_MAX_STEP       = 2'd2,
      CSR_WINDOW_LENGTH  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      VERDICT_GOOD   = 2'd0,
      VERDICT_MEDIUM = 2'd1,
      VERDICT_BAD    = 2'd2
   } verdict_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SUB,
      ST_ADD,
      ST_START,
      ST_DIV,
      ST_BAND,
      ST_STEP
   } state_type;

endpackage

@@ hw/rtl/mat_ram.sv @@
// ----------------------------------------------------------------------------
// mat_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module mat_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/mat_div.sv @@
// ----------------------------------------------------------------------------
// mat_div
// bit-serial restoring divider, signed sum by window length, one quotient
// bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module mat_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [mat_pkg::SUM_W-1:0]      dividend,
   input  logic [mat_pkg::EFF_W-1:0]             divisor,
   output logic                                  done,
   output logic signed [mat_pkg::SAMPLE_WIDTH-1:0] quotient
);

   import mat_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic                    neg_ff, neg_in;
   logic [SUM_W-1:0]        mag_ff, mag_in;
   logic [EFF_W-1:0]        rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [EFF_W:0]          trial;
   logic [SAMPLE_WIDTH-1:0] qmag;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      trial   = {rem_ff, mag_ff[SUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[SUM_W-1];
         mag_in  = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
         rem_in  = '0;
         cnt_in  = DIV_CNT_W'(SUM_W);
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = EFF_W'(trial - {1'b0, divisor});
            mag_in = {mag_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[EFF_W-1:0];
            mag_in = {mag_ff[SUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
   end

   assign qmag     = mag_ff[SAMPLE_WIDTH-1:0];
   assign quotient = neg_ff ? (~qmag + SAMPLE_WIDTH'(1)) : qmag;
   assign done     = done_ff;

endmodule

@@ hw/rtl/moving_average_trend_check.sv @@
// ----------------------------------------------------------------------------
// moving_average_trend_check
// sliding window mean of trend samples with band and step quality checks
// each request steps through read, sub, add, start, div, band and step; div waits on the
// 38-step serial divider, step while a result waits; new requests are taken only in idle
// reset: synchronous; series, verdict and registers return to defaults,
// window ram keeps its contents and needs no clearing pass
// ----------------------------------------------------------------------------
module moving_average_trend_check (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [mat_pkg::SAMPLE_WIDTH-1:0] req_sample,
   input  logic                                    req_new_series,
   input  logic                                    req_new_check,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [mat_pkg::SAMPLE_WIDTH-1:0] rsp_mean,
   output logic [1:0]                              rsp_verdict,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [mat_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [mat_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   import mat_pkg::*;

   state_type state_ff, state_in;

   logic signed [THRESH_W-1:0]     thresh_low_ff, thresh_low_in;
   logic signed [THRESH_W-1:0]     thresh_high_ff, thresh_high_in;
   logic [STEP_LIM_W-1:0]          max_step_ff, max_step_in;
   logic [WLEN_W-1:0]              wlen_ff, wlen_in;

   logic [EFF_W-1:0]               fill_ff, fill_in;
   logic [PTR_W-1:0]               wp_ff, wp_in;
   logic signed [SUM_W-1:0]        sum_ff, sum_in;
   logic signed [SAMPLE_WIDTH-1:0] prev_ff, prev_in;
   logic                           have_prev_ff, have_prev_in;
   verdict_type                    quality_ff, quality_in;

   logic signed [SAMPLE_WIDTH-1:0] sample_ff, sample_in;
   logic signed [SAMPLE_WIDTH-1:0] mean_ff, mean_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_mean_ff, rsp_mean_in;
   verdict_type                    rsp_verdict_ff, rsp_verdict_in;

   logic [EFF_W-1:0]               eff_w;
   logic [PTR_W-1:0]               wp_norm;
   logic [EFF_W-1:0]               wp_next;
   logic                           ram_wr_en;
   logic [SAMPLE_WIDTH-1:0]        ram_rd_data;
   logic                           div_start;
   logic                           div_done;
   logic signed [SAMPLE_WIDTH-1:0] div_quotient;
   logic signed [CMP_W-1:0]        mean_cmp, low_cmp, high_cmp;
   logic signed [DIFF_W-1:0]       diff;
   logic [STEP_W-1:0]              diff_abs;

   // effective window: zero counts as one, large values saturate
   always_comb begin
      if (wlen_ff == '0) begin
         eff_w = EFF_W'(1);
      end else if (EFF_W'(wlen_ff) > EFF_W'(MAX_WINDOW)) begin
         eff_w = EFF_W'(MAX_WINDOW);
      end else begin
         eff_w = EFF_W'(wlen_ff);
      end
   end

   assign wp_norm  = (EFF_W'(wp_ff) >= eff_w) ? '0 : wp_ff;
   assign wp_next  = EFF_W'(wp_ff) + EFF_W'(1);
   assign mean_cmp = CMP_W'(mean_ff);
   assign low_cmp  = CMP_W'(thresh_low_ff);
   assign high_cmp = CMP_W'(thresh_high_ff);
   assign diff     = DIFF_W'(mean_ff) - DIFF_W'(prev_ff);
   assign diff_abs = diff[DIFF_W-1] ? STEP_W'(-diff) : STEP_W'(diff);

   always_comb begin
      state_in       = state_ff;
      thresh_low_in  = thresh_low_ff;
      thresh_high_in = thresh_high_ff;
      max_step_in    = max_step_ff;
      wlen_in        = wlen_ff;
      fill_in        = fill_ff;
      wp_in          = wp_ff;
      sum_in         = sum_ff;
      prev_in        = prev_ff;
      have_prev_in   = have_prev_ff;
      quality_in     = quality_ff;
      sample_in      = sample_ff;
      mean_in        = mean_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_mean_in    = rsp_mean_ff;
      rsp_verdict_in = rsp_verdict_ff;
      ram_wr_en      = 1'b0;
      div_start      = 1'b0;

      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_THRESHOLD_LOW: begin
               thresh_low_in = csr_wdata[THRESH_W-1:0];
            end
            CSR_THRESHOLD_HIGH: begin
               thresh_high_in = csr_wdata[THRESH_W-1:0];
            end
            CSR_MAX_STEP: begin
               max_step_in = csr_wdata[STEP_LIM_W-1:0];
            end
            CSR_WINDOW_LENGTH: begin
               wlen_in      = csr_wdata[WLEN_W-1:0];
               fill_in      = '0;
               wp_in        = '0;
               sum_in       = '0;
               prev_in      = '0;
               have_prev_in = 1'b0;
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in = req_sample;
               if (req_new_series) begin
                  fill_in      = '0;
                  wp_in        = '0;
                  sum_in       = '0;
                  prev_in      = '0;
                  have_prev_in = 1'b0;
               end
               if (req_new_check) begin
                  quality_in = VERDICT_GOOD;
               end
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            wp_in    = wp_norm;
            state_in = ST_SUB;
         end
         ST_SUB: begin
            ram_wr_en = 1'b1;
            if (fill_ff >= eff_w) begin
               sum_in = sum_ff - SUM_W'($signed(ram_rd_data));
            end else begin
               fill_in = fill_ff + EFF_W'(1);
            end
            state_in = ST_ADD;
         end
         ST_ADD: begin
            sum_in   = sum_ff + SUM_W'(sample_ff);
            wp_in    = (wp_next >= eff_w) ? '0 : wp_next[PTR_W-1:0];
            state_in = ST_START;
         end
         ST_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               mean_in  = div_quotient;
               state_in = ST_BAND;
            end
         end
         ST_BAND: begin
            if (((mean_cmp < low_cmp) || (mean_cmp > high_cmp)) &&
                (quality_ff == VERDICT_GOOD)) begin
               quality_in = VERDICT_MEDIUM;
            end
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_verdict_in = quality_ff;
               if (have_prev_ff && (diff_abs > STEP_W'(max_step_ff))) begin
                  quality_in     = VERDICT_BAD;
                  rsp_verdict_in = VERDICT_BAD;
               end
               prev_in      = mean_ff;
               have_prev_in = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_mean_in  = mean_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         thresh_low_ff  <= {1'b1, {(THRESH_W-1){1'b0}}};
         thresh_high_ff <= {1'b0, {(THRESH_W-1){1'b1}}};
         max_step_ff    <= '1;
         wlen_ff        <= WLEN_W'(1);
         fill_ff        <= '0;
         wp_ff          <= '0;
         sum_ff         <= '0;
         prev_ff        <= '0;
         have_prev_ff   <= 1'b0;
         quality_ff     <= VERDICT_GOOD;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         thresh_low_ff  <= thresh_low_in;
         thresh_high_ff <= thresh_high_in;
         max_step_ff    <= max_step_in;
         wlen_ff        <= wlen_in;
         fill_ff        <= fill_in;
         wp_ff          <= wp_in;
         sum_ff         <= sum_in;
         prev_ff        <= prev_in;
         have_prev_ff   <= have_prev_in;
         quality_ff     <= quality_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      sample_ff      <= sample_in;
      mean_ff        <= mean_in;
      rsp_mean_ff    <= rsp_mean_in;
      rsp_verdict_ff <= rsp_verdict_in;
   end

   mat_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (MAX_WINDOW)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wp_ff),
      .wr_data (sample_ff),
      .rd_addr (wp_norm),
      .rd_data (ram_rd_data)
   );

   mat_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (eff_w),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_ready   = (state_ff == ST_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_mean    = rsp_mean_ff;
   assign rsp_verdict = rsp_verdict_ff;

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the moving average trend check: a scoreboard
// tracks window, running sum and verdict per request and compares every
// response, while randomized gaps and stalls exercise both handshakes
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mat_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int TAIL_CYCLES    = 60;
   localparam int HOLD_CYCLES    = 600;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 110;

   typedef struct {
      logic signed [SAMPLE_WIDTH-1:0] mean;
      verdict_type                    verdict;
   } trend_result_type;

   class trend_scoreboard_type;
      longint           thr_low;
      longint           thr_high;
      longint           step_lim;
      logic [6:0]       wlen;
      longint           ring [MAX_WINDOW];
      int               held;
      int               wr_ptr;
      longint           sum;
      longint           prev_mean;
      bit               have_prev;
      verdict_type      quality;
      trend_result_type expected [$];
      int               failures;
      int               reported;

      function new();
         thr_low   = -64'sd2147483648;
         thr_high  = 64'sd2147483647;
         step_lim  = 64'sd2147483647;
         wlen      = 7'd1;
         quality   = VERDICT_GOOD;
         failures  = 0;
         reported  = 0;
         clear_series();
      endfunction

      function void clear_series();
         held      = 0;
         wr_ptr    = 0;
         sum       = 0;
         prev_mean = 0;
         have_prev = 1'b0;
      endfunction

      function int effective_window();
         if (wlen == 7'd0) return 1;
         if (int'(wlen) > MAX_WINDOW) return MAX_WINDOW;
         return int'(wlen);
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_THRESHOLD_LOW: begin
               thr_low = longint'($signed(data));
            end
            CSR_THRESHOLD_HIGH: begin
               thr_high = longint'($signed(data));
            end
            CSR_MAX_STEP: begin
               step_lim = longint'({33'd0, data[30:0]});
            end
            CSR_WINDOW_LENGTH: begin
               wlen = data[6:0];
               clear_series();
            end
            default: ;
         endcase
      endfunction

      function void note_request(logic signed [SAMPLE_WIDTH-1:0] sample,
                                 bit new_series, bit new_check);
         int               w;
         longint           mean_wide;
         longint           delta;
         trend_result_type res;
         w = effective_window();
         if (new_series) clear_series();
         if (new_check) quality = VERDICT_GOOD;
         if (wr_ptr >= w) wr_ptr = 0;
         if (held >= w) sum -= ring[wr_ptr];
         else held++;
         ring[wr_ptr] = longint'(sample);
         sum += longint'(sample);
         wr_ptr++;
         if (wr_ptr >= w) wr_ptr = 0;
         mean_wide = sum / longint'(w);
         if ((mean_wide < thr_low || mean_wide > thr_high) && quality == VERDICT_GOOD)
            quality = VERDICT_MEDIUM;
         if (have_prev) begin
            delta = mean_wide - prev_mean;
            if (delta < 0) delta = -delta;
            if (delta > step_lim) quality = VERDICT_BAD;
         end
         prev_mean   = mean_wide;
         have_prev   = 1'b1;
         res.mean    = mean_wide[SAMPLE_WIDTH-1:0];
         res.verdict = quality;
         expected.push_back(res);
      endfunction

      function void check_response(logic signed [SAMPLE_WIDTH-1:0] mean, logic [1:0] verdict);
         trend_result_type res;
         if (expected.size() == 0) begin
            failures++;
            if (reported < 10)
               $display("unexpected response: mean %0d verdict %0d", mean, verdict);
            reported++;
            return;
         end
         res = expected.pop_front();
         if (mean !== res.mean || verdict !== res.verdict) begin
            failures++;
            if (reported < 10)
               $display("mismatch: mean exp %0d got %0d, verdict exp %0d got %0d",
                        res.mean, mean, res.verdict, verdict);
            reported++;
         end
      endfunction

      function int outstanding();
         return expected.size();
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic signed [SAMPLE_WIDTH-1:0] req_sample = '0;
   logic                           req_new_series = 1'b0;
   logic                           req_new_check = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic signed [SAMPLE_WIDTH-1:0] rsp_mean;
   logic [1:0]                     rsp_verdict;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [CSR_IDX_W-1:0]           csr_index = '0;
   logic [CSR_DATA_W-1:0]          csr_wdata = '0;

   trend_scoreboard_type board = new();
   bit                   steady = 1'b0;
   int                   rsp_hold = 0;
   int                   idle_cycles = 0;

   moving_average_trend_check dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .req_new_series (req_new_series),
      .req_new_check  (req_new_check),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_mean       (rsp_mean),
      .rsp_verdict    (rsp_verdict),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 90);
   endfunction

   // response side: check, then pick next ready
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            board.check_response(rsp_mean, rsp_verdict);
         if (rsp_hold > 0) begin
            stall_left = rsp_hold;
            rsp_hold   = 0;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_request(logic [SAMPLE_WIDTH-1:0] sample, bit new_series, bit new_check);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_sample     <= sample;
      req_new_series <= new_series;
      req_new_check  <= new_check;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(sample, new_series, new_check);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      while (board.outstanding() > 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_register(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(logic [31:0] low, logic [31:0] high, logic [31:0] step,
                            logic [31:0] wl);
      write_csr(CSR_THRESHOLD_LOW, low);
      write_csr(CSR_THRESHOLD_HIGH, high);
      write_csr(CSR_MAX_STEP, step);
      write_csr(CSR_WINDOW_LENGTH, wl);
   endtask

   function automatic logic [31:0] pick_sample(int level, int spread);
      int r;
      r = $urandom_range(0, 99);
      if (r < 6) return 32'h7FFF_FFFF;
      if (r < 12) return 32'h8000_0000;
      if (r < 25) return $urandom;
      return level + int'($urandom_range(0, 2 * spread)) - spread;
   endfunction

   task automatic run_random_phase(int phase_no, int count);
      int          level;
      int          spread;
      int          band;
      int          r;
      logic [31:0] low;
      logic [31:0] high;
      logic [31:0] step;
      logic [31:0] wl;
      level  = $urandom;
      spread = 1 << $urandom_range(4, 24);
      band   = $urandom_range(0, spread);
      r      = $urandom_range(0, 99);
      if (r < 15) begin
         low  = 32'h8000_0000;
         high = 32'h7FFF_FFFF;
      end else if (r < 25) begin
         low  = $urandom;
         high = $urandom;
      end else begin
         low  = level - band;
         high = level + band;
      end
      r = $urandom_range(0, 99);
      if (r < 60) step = $urandom_range(0, spread);
      else if (r < 75) step = 32'd0;
      else if (r < 90) step = 32'h7FFF_FFFF;
      else step = $urandom;
      step[31] = 1'($urandom_range(0, 1));
      wl = $urandom;
      r  = $urandom_range(0, 99);
      if (r < 50) wl[6:0] = 7'($urandom_range(1, 8));
      else if (r < 65) wl[6:0] = 7'($urandom_range(9, 63));
      else if (r < 75) wl[6:0] = 7'd64;
      else if (r < 85) wl[6:0] = 7'd0;
      else wl[6:0] = 7'($urandom_range(65, 127));
      configure(low, high, step, wl);
      steady = (phase_no == 2);
      for (int i = 0; i < count; i++) begin
         if (phase_no == 3 && i == 20) rsp_hold = HOLD_CYCLES;
         if (phase_no == 5 && i == 56) hold_until_drained();
         send_request(pick_sample(level, spread),
                      $urandom_range(0, 39) == 0, $urandom_range(0, 19) == 0);
      end
      hold_until_drained();
      steady = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults after reset, full-scale swings
      send_request(32'h7FFF_FFFF, 1'b1, 1'b1);
      send_request(32'h8000_0000, 1'b0, 1'b0);
      send_request(32'h0000_0000, 1'b0, 1'b1);
      send_request(32'hFFFF_FFFF, 1'b1, 1'b1);
      send_request(32'h0000_0001, 1'b0, 1'b0);
      hold_until_drained();

      // narrow band, zero step, zero length treated as one
      configure(32'hFFFF_0000, 32'h0001_0000, 32'h0000_0000, 32'hFFFF_FF80);
      send_request(32'h0001_0000, 1'b0, 1'b1);
      send_request(32'h0001_0000, 1'b0, 1'b0);
      send_request(32'h0001_0001, 1'b0, 1'b0);
      send_request(32'hFFFF_0000, 1'b0, 1'b1);
      send_request(32'hFFFE_FFFF, 1'b1, 1'b1);
      hold_until_drained();

      // empty band, oversized length saturates, filling window
      configure(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_007F);
      send_request(32'h7FFF_FFFF, 1'b0, 1'b1);
      for (int i = 0; i < 5; i++) send_request(32'h7FFF_FFFF, 1'b0, 1'b0);
      send_request(32'h8000_0000, 1'b1, 1'b0);
      hold_until_drained();

      // short window wrapping around
      configure(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0003);
      send_request(32'd3, 1'b0, 1'b1);
      send_request(32'd6, 1'b0, 1'b0);
      send_request(32'd9, 1'b0, 1'b0);
      send_request(-32'sd30, 1'b0, 1'b0);
      send_request(32'd0, 1'b0, 1'b0);
      send_request(32'd12, 1'b0, 1'b0);
      hold_until_drained();

      for (int p = 0; p < RANDOM_PHASES; p++) run_random_phase(p, PHASE_ITEMS);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.failures == 0 && board.outstanding() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
